// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never be true while out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/fsmw_pkg.sv =====
package fsmw_pkg;

	localparam int unsigned COPY_COUNT = 2;
	localparam int unsigned ADDR_W = 24;
	localparam int unsigned SIZE_W = 13;
	localparam int unsigned BOFF_W = 12;
	localparam int unsigned COPY_W = 2;
	localparam logic [SIZE_W-1:0] COUNT_MAX = {SIZE_W{1'b1}};

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_ERASE      = 3'd1,
		PH_ERASE_WAIT = 3'd2,
		PH_PROGRAM    = 3'd3,
		PH_XFER_WAIT  = 3'd4,
		PH_PROG_WAIT  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_ERASE   = 2'd1,
		CMD_PROGRAM = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_BASE_ADDRESS = 2'd0,
		REG_SPARE_OFFSET = 2'd1,
		REG_PAGE_SIZE    = 2'd2,
		REG_SECTOR_SIZE  = 2'd3
	} reg_idx_t;

	localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS = 24'd0;
	localparam logic [ADDR_W-1:0] RST_SPARE_OFFSET = 24'd262144;
	localparam logic [SIZE_W-1:0] RST_PAGE_SIZE = 13'd256;
	localparam logic [SIZE_W-1:0] RST_SECTOR_SIZE = 13'd4096;

	typedef struct packed {
		logic [ADDR_W-1:0] base_address;
		logic [ADDR_W-1:0] spare_offset;
		logic [SIZE_W-1:0] page_size;
		logic [SIZE_W-1:0] sector_size;
	} cfg_t;

	typedef struct packed {
		logic op;
		logic flash_busy;
		logic transfer_done;
	} item_t;

	typedef struct packed {
		cmd_t              command;
		logic [ADDR_W-1:0] flash_address;
		logic [BOFF_W-1:0] buffer_offset;
		phase_t            phase_code;
		logic              idle;
	} result_t;

endpackage

// ===== rtl/fsmw_seq.sv =====
module fsmw_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  fsmw_pkg::cfg_t   cfg,
	input  logic             step,
	input  fsmw_pkg::item_t  item,
	output fsmw_pkg::result_t result
);
	import fsmw_pkg::*;

	phase_t              phase_q, phase_d;
	logic [SIZE_W-1:0]   bytes_q, bytes_d;
	logic [COPY_W-1:0]   copies_q, copies_d;
	logic [ADDR_W-1:0]   target_q, target_d;
	logic                latch_q, latch_d;
	logic [SIZE_W:0]     bytes_sum;
	logic [COPY_W-1:0]   copies_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bytes_q  <= '0;
			copies_q <= '0;
			target_q <= '0;
			latch_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			bytes_q  <= bytes_d;
			copies_q <= copies_d;
			target_q <= target_d;
			latch_q  <= latch_d;
		end
	end

	assign bytes_sum  = {1'b0, bytes_q} + {1'b0, cfg.page_size};
	assign copies_inc = copies_q + COPY_W'(1);

	always_comb begin
		phase_d  = phase_q;
		bytes_d  = bytes_q;
		copies_d = copies_q;
		target_d = target_q;
		latch_d  = latch_q;
		result.command       = CMD_NONE;
		result.flash_address = '0;
		result.buffer_offset = '0;
		if (item.op) begin
			// start only takes effect from idle
			if (phase_q == PH_IDLE) begin
				target_d = cfg.base_address;
				bytes_d  = '0;
				copies_d = '0;
				phase_d  = PH_ERASE;
			end
		end else begin
			latch_d = latch_q | item.transfer_done;
			case (phase_q)
				PH_ERASE: begin
					result.command       = CMD_ERASE;
					result.flash_address = target_q;
					phase_d              = PH_ERASE_WAIT;
				end
				PH_ERASE_WAIT: begin
					if (!item.flash_busy) phase_d = PH_PROGRAM;
				end
				PH_PROGRAM: begin
					result.command       = CMD_PROGRAM;
					result.flash_address = target_q + {{(ADDR_W-SIZE_W){1'b0}}, bytes_q};
					result.buffer_offset = bytes_q[BOFF_W-1:0];
					phase_d              = PH_XFER_WAIT;
				end
				PH_XFER_WAIT: begin
					if (latch_d) begin
						// saturating byte count
						bytes_d = bytes_sum[SIZE_W] ? COUNT_MAX : bytes_sum[SIZE_W-1:0];
						latch_d = 1'b0;
						phase_d = PH_PROG_WAIT;
					end
				end
				PH_PROG_WAIT: begin
					if (!item.flash_busy) begin
						if (bytes_q < cfg.sector_size) begin
							phase_d = PH_PROGRAM;
						end else begin
							bytes_d = '0;
							if (copies_inc < COPY_W'(COPY_COUNT)) begin
								copies_d = copies_inc;
								target_d = target_q + cfg.spare_offset;
								phase_d  = PH_ERASE;
							end else begin
								copies_d = '0;
								phase_d  = PH_IDLE;
							end
						end
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		result.phase_code = phase_d;
		result.idle       = (phase_d == PH_IDLE);
	end

endmodule

// ===== rtl/flash_sector_mirror_writer_unit.sv =====
// flash sector mirror writer
// sequences a save of one sector buffer to flash, written twice: the primary
// copy at base_address and a spare copy at base_address plus spare_offset.
// input channel (in_valid/in_ready): each item is either a start request
// (op = 1) or a status tick (op = 0) carrying flash_busy and transfer_done.
// output channel (out_valid/out_ready): exactly one result item per input
// item: the command to issue (erase or page program) with its address and
// buffer offset, the phase after the step and the idle flag.
// config channel (cfg_valid/cfg_ready): always ready, writes base address,
// spare offset, page size and sector size; write only while the block idles.
// an item is registered on accept in the input register, and the sequencer
// step then loads the output register once that register can take a result.
// throughput: one item per cycle while the receiver keeps taking results.
// when the receiver stalls, the output register holds its item and the input
// register still takes one more item; further items wait on in_ready.
// reset clears the sequencer to idle, empties both registers and restores
// the configuration register defaults.
module flash_sector_mirror_writer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [fsmw_pkg::ADDR_W-1:0]     cfg_data,
	// input items
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic                            flash_busy,
	input  logic                            transfer_done,
	// result items
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      command,
	output logic [fsmw_pkg::ADDR_W-1:0]     flash_address,
	output logic [fsmw_pkg::BOFF_W-1:0]     buffer_offset,
	output logic [2:0]                      phase_code,
	output logic                            idle
);
	import fsmw_pkg::*;

	`include "assert_macros.svh"

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	// config registers, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address <= RST_BASE_ADDRESS;
			cfg_q.spare_offset <= RST_SPARE_OFFSET;
			cfg_q.page_size    <= RST_PAGE_SIZE;
			cfg_q.sector_size  <= RST_SECTOR_SIZE;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_BASE_ADDRESS: cfg_q.base_address <= cfg_data;
				REG_SPARE_OFFSET: cfg_q.spare_offset <= cfg_data;
				REG_PAGE_SIZE:    cfg_q.page_size    <= cfg_data[SIZE_W-1:0];
				REG_SECTOR_SIZE:  cfg_q.sector_size  <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// the stage-1 item steps the sequencer when the output register frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op            <= op;
			item_s1.flash_busy    <= flash_busy;
			item_s1.transfer_done <= transfer_done;
		end
	end

	// sequencer state and next-step logic
	fsmw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (advance),
		.item   (item_s1),
		.result (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_d;
	end

	assign out_valid     = out_valid_q;
	assign command       = res_q.command;
	assign flash_address = res_q.flash_address;
	assign buffer_offset = res_q.buffer_offset;
	assign phase_code    = res_q.phase_code;
	assign idle          = res_q.idle;

	// a stalled stage-1 item is never dropped
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && out_valid_q && !out_ready, valid_s1)
	// an erase is always followed by the erase wait phase
	`ASSERT_IMPLIES(a_erase_phase, clk, arst_n, out_valid_q && res_q.command == CMD_ERASE,
		res_q.phase_code == PH_ERASE_WAIT)
	// a page program is always followed by the transfer wait phase
	`ASSERT_IMPLIES(a_prog_phase, clk, arst_n, out_valid_q && res_q.command == CMD_PROGRAM,
		res_q.phase_code == PH_XFER_WAIT)
	// buffer offset only accompanies a page program
	`ASSERT_IMPLIES(a_boff_prog, clk, arst_n, out_valid_q && res_q.buffer_offset != '0,
		res_q.command == CMD_PROGRAM)

endmodule

// ===== bench/tb_flash_sector_mirror_writer_unit.sv =====
`timescale 1ns / 1ps

// mirrored sector save sequencer bench
module tb_flash_sector_mirror_writer_unit;
	import fsmw_pkg::*;

	// cycles with no item moving on any channel before the run is called hung
	localparam int STALL_LIMIT = 2000;
	// random stimulus stops once this many input items have gone in
	localparam int ITEM_TARGET = 1500;
	// result latency plus margin, used when the block must be quiet
	localparam int DRAIN_CYCLES = 6;

	logic clk;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [ADDR_W-1:0] cfg_data = '0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic op = 1'b0;
	logic flash_busy = 1'b0;
	logic transfer_done = 1'b0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] command;
	logic [ADDR_W-1:0] flash_address;
	logic [BOFF_W-1:0] buffer_offset;
	logic [2:0] phase_code;
	logic idle;

	flash_sector_mirror_writer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.flash_busy(flash_busy),
		.transfer_done(transfer_done),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.command(command),
		.flash_address(flash_address),
		.buffer_offset(buffer_offset),
		.phase_code(phase_code),
		.idle(idle)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// sequencer mirror: our own copy of the save state and registers
	// ---------------------------------------------------------------
	cfg_t reg_shadow = '{RST_BASE_ADDRESS, RST_SPARE_OFFSET, RST_PAGE_SIZE, RST_SECTOR_SIZE};
	phase_t seq_phase = PH_IDLE;
	logic [SIZE_W-1:0] seq_written = '0;
	logic [COPY_W-1:0] seq_copies = '0;
	logic [ADDR_W-1:0] seq_target = '0;
	logic seq_latch = 1'b0;

	// step results still owed by the block, oldest first
	result_t owed_steps[$];

	int items_sent = 0;
	int mismatches = 0;
	int results_seen = 0;

	// one sequencer step for an accepted item, returns the result it owes
	function automatic result_t advance_save_sequence(item_t it);
		result_t r;
		logic [SIZE_W:0] sum;
		r.command = CMD_NONE;
		r.flash_address = '0;
		r.buffer_offset = '0;
		if (it.op) begin
			// start only takes effect from idle, its status bits are don't-care
			if (seq_phase == PH_IDLE) begin
				seq_target = reg_shadow.base_address;
				seq_written = '0;
				seq_copies = '0;
				seq_phase = PH_ERASE;
			end
		end else begin
			// any tick can set the latch, only transfer wait clears it
			if (it.transfer_done)
				seq_latch = 1'b1;
			case (seq_phase)
				PH_ERASE: begin
					r.command = CMD_ERASE;
					r.flash_address = seq_target;
					seq_phase = PH_ERASE_WAIT;
				end
				PH_ERASE_WAIT: begin
					if (!it.flash_busy)
						seq_phase = PH_PROGRAM;
				end
				PH_PROGRAM: begin
					r.command = CMD_PROGRAM;
					r.flash_address = seq_target + ADDR_W'(seq_written);
					r.buffer_offset = seq_written[BOFF_W-1:0];
					seq_phase = PH_XFER_WAIT;
				end
				PH_XFER_WAIT: begin
					if (seq_latch) begin
						// byte count sticks at all ones
						sum = {1'b0, seq_written} + {1'b0, reg_shadow.page_size};
						seq_written = (sum > COUNT_MAX) ? COUNT_MAX : sum[SIZE_W-1:0];
						seq_latch = 1'b0;
						seq_phase = PH_PROG_WAIT;
					end
				end
				PH_PROG_WAIT: begin
					if (!it.flash_busy) begin
						if (seq_written < reg_shadow.sector_size) begin
							seq_phase = PH_PROGRAM;
						end else begin
							seq_written = '0;
							seq_copies = seq_copies + 1'b1;
							if (seq_copies < COPY_COUNT) begin
								seq_target = seq_target + reg_shadow.spare_offset;
								seq_phase = PH_ERASE;
							end else begin
								seq_copies = '0;
								seq_phase = PH_IDLE;
							end
						end
					end
				end
				default: seq_phase = PH_IDLE;
			endcase
		end
		r.phase_code = seq_phase;
		r.idle = (seq_phase == PH_IDLE);
		return r;
	endfunction

	// stall length: mostly short, now and then a long one
	function automatic int stall_length();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------
	// offer one item and hold it until taken; in_valid stays high on return,
	// so the caller either offers the next item in the same step or lowers it
	task automatic feed_item(item_t it, bit use_fixed, result_t fixed_res);
		int gap;
		result_t r;
		// every few hundred items a burst with no gaps at all
		if (items_sent % 300 < 50 || $urandom_range(0, 99) < 65)
			gap = 0;
		else
			gap = stall_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		flash_busy <= it.flash_busy;
		transfer_done <= it.transfer_done;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		r = advance_save_sequence(it);
		// directed rows may carry a hand-written expectation instead
		owed_steps.push_back(use_fixed ? fixed_res : r);
	endtask

	// stop offering and wait until every owed result is out
	task automatic drain_block();
		in_valid <= 1'b0;
		while (owed_steps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register write; cfg_valid left high for a following write
	task automatic write_register(reg_idx_t idx, logic [ADDR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_BASE_ADDRESS: reg_shadow.base_address = value;
			REG_SPARE_OFFSET: reg_shadow.spare_offset = value;
			REG_PAGE_SIZE:    reg_shadow.page_size = value[SIZE_W-1:0];
			REG_SECTOR_SIZE:  reg_shadow.sector_size = value[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	// new register set while the block is quiet; size registers get junk
	// above bit 12 half the time, which the block must drop
	task automatic load_registers(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] spare,
			int page, int sector);
		logic [ADDR_W-SIZE_W-1:0] junk_p;
		logic [ADDR_W-SIZE_W-1:0] junk_s;
		junk_p = $urandom_range(0, 1) ? (ADDR_W-SIZE_W)'($urandom) : '0;
		junk_s = $urandom_range(0, 1) ? (ADDR_W-SIZE_W)'($urandom) : '0;
		drain_block();
		write_register(REG_BASE_ADDRESS, base);
		write_register(REG_SPARE_OFFSET, spare);
		write_register(REG_PAGE_SIZE, {junk_p, SIZE_W'(page)});
		write_register(REG_SECTOR_SIZE, {junk_s, SIZE_W'(sector)});
		cfg_valid <= 1'b0;
	endtask

	// run whole saves with random status ticks, plus some noise: stray ticks
	// while idle and start requests that land mid-save
	task automatic run_saves(int saves, int cap);
		int started;
		int n;
		item_t it;
		result_t none_res;
		started = 0;
		n = 0;
		none_res = '0;
		while (n < cap && !(seq_phase == PH_IDLE && started >= saves)) begin
			if (seq_phase == PH_IDLE) begin
				it.op = ($urandom_range(0, 9) < 8);
				if (it.op)
					started++;
			end else begin
				it.op = ($urandom_range(0, 19) == 0);
			end
			it.flash_busy = ($urandom_range(0, 2) == 0);
			it.transfer_done = ($urandom_range(0, 2) == 0);
			feed_item(it, 1'b0, none_res);
			n++;
		end
	endtask

	// opening script under reset registers (base 0, page 256, sector 4096)
	typedef struct {
		item_t stim;
		bit fixed;
		result_t want;
	} script_row_t;

	script_row_t opening_script [16] = '{
		// tick after reset: nothing to do
		'{'{1'b0, 1'b0, 1'b0}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_IDLE, 1'b1}},
		// start with both status bits set, bits must be ignored
		'{'{1'b1, 1'b1, 1'b1}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_ERASE, 1'b0}},
		// start while already running is dropped
		'{'{1'b1, 1'b0, 1'b0}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_ERASE, 1'b0}},
		'{'{1'b0, 1'b1, 1'b0}, 1'b1, '{CMD_ERASE, 24'd0, 12'd0, PH_ERASE_WAIT, 1'b0}},
		// early transfer pulse during erase wait gets latched
		'{'{1'b0, 1'b1, 1'b1}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_ERASE_WAIT, 1'b0}},
		'{'{1'b0, 1'b0, 1'b0}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_PROGRAM, 1'b0}},
		'{'{1'b0, 1'b1, 1'b0}, 1'b1, '{CMD_PROGRAM, 24'd0, 12'd0, PH_XFER_WAIT, 1'b0}},
		// remembered pulse moves us on without a new one
		'{'{1'b0, 1'b1, 1'b0}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_PROG_WAIT, 1'b0}},
		'{'{1'b0, 1'b1, 1'b0}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_PROG_WAIT, 1'b0}},
		// start mid-save carrying a done bit: neither takes effect
		'{'{1'b1, 1'b1, 1'b1}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_PROG_WAIT, 1'b0}},
		'{'{1'b0, 1'b0, 1'b0}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_PROGRAM, 1'b0}},
		'{'{1'b0, 1'b0, 1'b0}, 1'b1, '{CMD_PROGRAM, 24'd256, 12'd256, PH_XFER_WAIT, 1'b0}},
		// no latch left over from the ignored start
		'{'{1'b0, 1'b0, 1'b0}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_XFER_WAIT, 1'b0}},
		'{'{1'b0, 1'b1, 1'b1}, 1'b1, '{CMD_NONE, 24'd0, 12'd0, PH_PROG_WAIT, 1'b0}},
		// from here the mirror decides
		'{'{1'b0, 1'b0, 1'b0}, 1'b0, '{CMD_NONE, 24'd0, 12'd0, PH_IDLE, 1'b0}},
		'{'{1'b0, 1'b0, 1'b1}, 1'b0, '{CMD_NONE, 24'd0, 12'd0, PH_IDLE, 1'b0}}
	};

	// main stimulus thread
	initial begin
		int page;
		int sector;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] spare;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_script[i])
			feed_item(opening_script[i].stim, opening_script[i].fixed, opening_script[i].want);
		// finish that save and run one more under reset registers
		run_saves(1, 4000);

		// program addresses wrap past the top, spare copy wraps too
		load_registers(24'hFFFFFE, 24'hFFFFFF, 1, 3);
		run_saves(1, 4000);
		// one full-sector page, spare copy on top of the primary
		load_registers(24'd0, 24'd0, 4096, 4096);
		run_saves(1, 4000);
		// widest sizes: a single page fills the whole sector, top base address
		load_registers(24'hFFFFFF, 24'h800000, 8191, 8191);
		run_saves(1, 4000);
		// count saturates mid-sector, buffer offset wraps at 4 KiB
		load_registers(24'h123456, 24'h040000, 5000, 8191);
		run_saves(1, 4000);
		// zero sector size still programs one page per copy
		load_registers(24'h00F000, 24'h001000, 0, 0);
		run_saves(2, 4000);
		load_registers(24'hABCDEF, 24'h654321, 7, 0);
		run_saves(1, 4000);

		// random register sets, sizes chosen so a copy stays a handful of pages
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) < 6) begin
				sector = $urandom_range(0, 128);
				page = $urandom_range(sector / 8 + 1, sector / 2 + 1);
			end else begin
				sector = $urandom_range(0, 8191);
				page = $urandom_range(sector / 8 + 1, 8191);
			end
			case ($urandom_range(0, 5))
				0: base = '0;
				1: base = '1;
				default: base = ADDR_W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: spare = '0;
				1: spare = '1;
				default: spare = ADDR_W'($urandom);
			endcase
			load_registers(base, spare, page, sector);
			run_saves($urandom_range(1, 3), 4000);
		end

		// zero page size with a real sector never finishes, so it goes last
		load_registers(24'h0A0000, 24'h040000, 0, 5);
		run_saves(1, 40);

		drain_block();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// ---------------------------------------------------------------
	// output side: random back-pressure and result compare
	// ---------------------------------------------------------------
	task automatic compare_step();
		result_t want;
		if (owed_steps.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with none owed: cmd %0d addr %h boff %h phase %0d idle %0b",
					$realtime, command, flash_address, buffer_offset, phase_code, idle);
			return;
		end
		want = owed_steps.pop_front();
		if (command !== want.command || flash_address !== want.flash_address ||
				buffer_offset !== want.buffer_offset || phase_code !== want.phase_code ||
				idle !== want.idle) begin
			mismatches++;
			if (mismatches <= 10) begin
				$write("%0t: step mismatch: want cmd %0d addr %h boff %h phase %0d idle %0b",
					$realtime, want.command, want.flash_address, want.buffer_offset,
					want.phase_code, want.idle);
				$display(" / got cmd %0d addr %h boff %h phase %0d idle %0b",
					command, flash_address, buffer_offset, phase_code, idle);
			end
		end
	endtask

	initial begin
		int hold_left;
		int cycle_no;
		bit squeezed;
		hold_left = 0;
		cycle_no = 0;
		squeezed = 1'b0;
		forever begin
			@(posedge clk);
			cycle_no++;
			if (arst_n && out_valid && out_ready) begin
				compare_step();
				results_seen++;
			end
			if (hold_left > 0)
				hold_left--;
			// one long hold-off so the block backs up into its input
			else if (!squeezed && results_seen >= 200) begin
				hold_left = 80;
				squeezed = 1'b1;
			end
			// quiet windows with the receiver always ready
			else if ((cycle_no / 300) % 4 != 0 && $urandom_range(0, 5) == 0)
				hold_left = stall_length();
			out_ready <= arst_n && (hold_left == 0);
		end
	end

	// hang detector: no item moved on any channel for too long
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fsmw_pkg.sv
rtl/fsmw_seq.sv
rtl/flash_sector_mirror_writer_unit.sv
bench/tb_flash_sector_mirror_writer_unit.sv
